// ===== design/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants for the code bit packer: field widths, request
// modes, queue entry layout and back end state.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

   localparam int SYM_W       = 8;
   localparam int WORD_W      = 32;
   localparam int LEN_W       = 6;
   localparam int BYTE_W      = 8;
   localparam int PEND_W      = 7;
   localparam int CNT_W       = 3;
   localparam int MODE_W      = 2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD   = 2'd0,
      MODE_ENCODE = 2'd1,
      MODE_FLUSH  = 2'd2
   } mode_type;

   typedef enum logic {
      OP_ENCODE = 1'b0,
      OP_FLUSH  = 1'b1
   } op_type;

   typedef enum logic {
      B_IDLE = 1'b0,
      B_RUN  = 1'b1
   } back_state_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   bits;
      logic [LEN_W-1:0]    len;
   } job_type;

endpackage

`default_nettype wire

// ===== design/huffman_code_bit_packer.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Code table plus msb-first bit packer for a prefix-code encoder.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  mode, symbol, code_word,
//                                              code_length
//   rsp      out        rsp_valid / rsp_stall  out_byte, last_byte
//
// The front end takes one request per cycle while its table read stage can
// move on; a load finishes there. The packer fetches an encode job, emits
// its full bytes, one per cycle while rsp_stall is low (the sustained rate),
// keeps leftover bits pending, and takes no new job until done. Reset is
// synchronous and clears the code length valid flags, pending bits and queue.
// rsp_stall holds the output byte; req_stall rises if a job finds the queue full.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_bit_packer
   import hcbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [SYM_W-1:0]    req_symbol,
   input  wire logic [WORD_W-1:0]   req_code_word,
   input  wire logic [LEN_W-1:0]    req_code_length,
   output      logic                rsp_valid,
   input  wire logic                rsp_stall,
   output      logic [BYTE_W-1:0]   rsp_out_byte,
   output      logic [0:0]          rsp_last_byte
);

   logic    push;
   job_type push_job;
   logic    q_full;
   logic    pop;
   job_type pop_job;
   logic    q_empty;

   hcbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_code_word   (req_code_word),
      .req_code_length (req_code_length),
      .push            (push),
      .push_job        (push_job),
      .q_full          (q_full)
   );

   hcbp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .q_full   (q_full),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_empty  (q_empty)
   );

   hcbp_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_job       (pop_job),
      .q_empty       (q_empty),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

endmodule

`default_nettype wire

// ===== design/hcbp_front.sv =====
// ----------------------------------------------------------------------------
// hcbp_front
// Accepts requests, owns the code table, and turns encode and flush requests
// into packer jobs. Loads, unknown modes, out-of-range symbols and empty codes
// end here.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_front
   import hcbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire logic [MODE_W-1:0]   req_mode,
   input  wire logic [SYM_W-1:0]    req_symbol,
   input  wire logic [WORD_W-1:0]   req_code_word,
   input  wire logic [LEN_W-1:0]    req_code_length,
   output      logic                push,
   output      job_type             push_job,
   input  wire logic                q_full
);

   localparam int IDX_W   = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int LEN_CAP = (MAX_CODE_LEN < WORD_W) ? MAX_CODE_LEN : WORD_W;
   localparam logic [LEN_W-1:0] LEN_CAP_V = LEN_W'(LEN_CAP);
   localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(SYMBOL_COUNT);

   logic [WORD_W-1:0] code_mem [SYMBOL_COUNT];
   logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];
   logic              len_vld_ff [SYMBOL_COUNT];

   logic [WORD_W-1:0] rd_bits_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic              rd_vld_ff;

   logic              s1_valid_ff, s1_valid_in;
   op_type            s1_op_ff, s1_op_in;

   logic              accept;
   logic              in_range;
   logic              is_load, is_encode, is_flush;
   logic [IDX_W-1:0]  idx;
   logic [LEN_W-1:0]  sat_len;
   logic [LEN_W-1:0]  rd_len;
   logic              s1_keep;
   logic              s1_move;

   always_comb begin
      idx      = req_symbol[IDX_W-1:0];
      in_range = {1'b0, req_symbol} < SYM_LIMIT;
      sat_len  = (req_code_length > LEN_CAP_V) ? LEN_CAP_V : req_code_length;
      is_load   = 1'b0;
      is_encode = 1'b0;
      is_flush  = 1'b0;
      case (req_mode)
         MODE_LOAD:   is_load   = 1'b1;
         MODE_ENCODE: is_encode = 1'b1;
         MODE_FLUSH:  is_flush  = 1'b1;
         default:     ;
      endcase
   end

   // entries never loaded read back as no code
   assign rd_len  = rd_vld_ff ? rd_len_ff : '0;
   assign s1_keep = (s1_op_ff == OP_FLUSH) || (rd_len != '0);

   always_comb begin
      s1_move   = s1_valid_ff && (!s1_keep || !q_full);
      push      = s1_valid_ff && s1_keep && !q_full;
      req_stall = s1_valid_ff && !s1_move;
      accept    = req_valid && !req_stall;

      push_job.op   = s1_op_ff;
      push_job.bits = rd_bits_ff;
      push_job.len  = rd_len;

      s1_valid_in = s1_valid_ff;
      s1_op_in    = s1_op_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      if (accept) begin
         s1_valid_in = is_flush || (is_encode && in_range);
         s1_op_in    = is_flush ? OP_FLUSH : OP_ENCODE;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && is_load && in_range) begin
         code_mem[idx] <= req_code_word;
         len_mem[idx]  <= sat_len;
      end
      if (accept) begin
         rd_bits_ff <= code_mem[idx];
         rd_len_ff  <= len_mem[idx];
         rd_vld_ff  <= len_vld_ff[idx];
      end
      s1_op_ff <= s1_op_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            len_vld_ff[i] <= 1'b0;
         end
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && is_load && in_range) begin
            len_vld_ff[idx] <= 1'b1;
         end
         s1_valid_ff <= s1_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/hcbp_queue.sv =====
// ----------------------------------------------------------------------------
// hcbp_queue
// Short job queue between the front end and the packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_queue
   import hcbp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output      logic    q_full,
   input  wire logic    pop,
   output      job_type pop_job,
   output      logic    q_empty
);

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign q_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_full)
      else $error("job pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_empty)
      else $error("job popped from empty queue");

endmodule

`default_nettype wire

// ===== design/hcbp_back.sv =====
// ----------------------------------------------------------------------------
// hcbp_back
// Bit packer: shifts each job's code bits, first bit first, into the byte
// accumulator and, while rsp_stall is low, emits one completed byte per
// cycle through an output register; a flush emits the pending partial byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_back
   import hcbp_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire job_type            pop_job,
   input  wire logic               q_empty,
   output      logic               pop,
   output      logic               rsp_valid,
   input  wire logic               rsp_stall,
   output      logic [BYTE_W-1:0]  rsp_out_byte,
   output      logic [0:0]         rsp_last_byte
);

   back_state_type     state_ff, state_in;
   op_type             op_ff, op_in;
   logic [WORD_W-1:0]  code_ff, code_in;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [PEND_W-1:0]  pend_ff, pend_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               out_free;
   logic [3:0]         room;
   logic [LEN_W-1:0]   room6;
   logic [BYTE_W-1:0]  top8;
   logic [14:0]        pend_wide;
   logic [BYTE_W-1:0]  full_byte;
   logic [BYTE_W-1:0]  part_wide;
   logic               fills;
   logic               emit;
   logic               done;

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      room      = 4'd8 - {1'b0, cnt_ff};
      room6     = LEN_W'(room);
      top8      = code_ff[WORD_W-1 -: BYTE_W];
      pend_wide = {8'b0, pend_ff} << room;
      full_byte = pend_wide[BYTE_W-1:0] | (top8 >> cnt_ff);
      // fewer bits left than the byte needs: append them to the pending bits
      part_wide = ({1'b0, pend_ff} << rem_ff[2:0])
                | (top8 >> (4'd8 - {1'b0, rem_ff[2:0]}));
      fills     = (rem_ff >= room6);
   end

   // next state
   always_comb begin
      done = 1'b0;
      case (op_ff)
         OP_ENCODE: done = (rem_ff == '0);
         OP_FLUSH:  done = (cnt_ff == '0) || out_free;
         default:   done = 1'b1;
      endcase
      state_in = state_ff;
      case (state_ff)
         B_IDLE:  if (!q_empty) state_in = B_RUN;
         B_RUN:   if (done) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop         = 1'b0;
      emit        = 1'b0;
      op_in       = op_ff;
      code_in     = code_ff;
      rem_in      = rem_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               op_in   = pop_job.op;
               // left-align the code so its first bit sits in the msb
               code_in = pop_job.bits << (LEN_W'(WORD_W) - pop_job.len);
               rem_in  = pop_job.len;
            end
         end
         B_RUN: begin
            if (op_ff == OP_FLUSH) begin
               if (cnt_ff != '0 && out_free) begin
                  emit        = 1'b1;
                  rsp_byte_in = pend_wide[BYTE_W-1:0];
                  rsp_last_in = 1'b1;
                  pend_in     = '0;
                  cnt_in      = '0;
               end
            end else if (rem_ff != '0) begin
               if (fills) begin
                  if (out_free) begin
                     emit        = 1'b1;
                     rsp_byte_in = full_byte;
                     rsp_last_in = ((rem_ff - room6) < LEN_W'(BYTE_W));
                     code_in     = code_ff << room;
                     rem_in      = rem_ff - room6;
                     pend_in     = '0;
                     cnt_in      = '0;
                  end
               end else begin
                  pend_in = part_wide[PEND_W-1:0];
                  cnt_in  = cnt_ff + rem_ff[CNT_W-1:0];
                  rem_in  = '0;
               end
            end
         end
         default: ;
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      code_ff     <= code_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rem_ff       <= '0;
         pend_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rem_ff       <= rem_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_RUN && op_ff == OP_FLUSH && out_free) |=> (cnt_ff == '0))
      else $error("flush left bits pending");

   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (emit && !rsp_last_in) |=> (state_ff == B_RUN && rem_ff >= LEN_W'(BYTE_W)))
      else $error("byte not marked last but no full byte follows");

   a_emit_has_room: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("byte emitted over an unaccepted one");

endmodule

`default_nettype wire
